>>> rtl/dstq_pkg.sv
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and helpers for the deadline-sorted timeout queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TASK_W    = 4;
	localparam int TICK_W    = 32;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int SCAN_W    = (MAX_TASKS > 2) ? $clog2(MAX_TASKS - 1) : 1;
	localparam int FLAGS_W   = 1 << TASK_W;

	typedef enum logic [1:0] {
		FN_INSERT   = 2'd0,
		FN_REMOVE   = 2'd1,
		FN_TAKE_DUE = 2'd2
	} func_t;

	// operation broadcast to every cell of the row
	typedef enum logic [2:0] {
		CP_HOLD,
		CP_CMP_INS,
		CP_CMP_REM,
		CP_SCAN,
		CP_INS,
		CP_REM,
		CP_POP
	} cell_op_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [TICK_W-1:0] tick;
	} entry_t;

	typedef struct packed {
		cell_op_t          op;
		logic [TASK_W-1:0] task_id;
		logic [TICK_W-1:0] tick;
		logic [CNT_W-1:0]  used;
	} bcast_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [TASK_W-1:0] task_id;
		logic [TICK_W-1:0] due_tick;
		logic [TICK_W-1:0] now_tick;
	} in_t;

	typedef struct packed {
		logic              ok;
		logic [TASK_W-1:0] taken_task;
		logic [CNT_W-1:0]  queue_count;
	} out_t;

	// a is before b under wraparound ordering
	function automatic logic tick_before(input logic [TICK_W-1:0] a,
		input logic [TICK_W-1:0] b);
		logic [TICK_W-1:0] d;
		d = a - b;
		return d[TICK_W-1];
	endfunction

	function automatic logic tick_reached(input logic [TICK_W-1:0] now,
		input logic [TICK_W-1:0] deadline);
		logic [TICK_W-1:0] d;
		d = now - deadline;
		return ~d[TICK_W-1];
	endfunction

endpackage

>>> rtl/dstq_cell.sv
// ----------------------------------------------------------------------------
// dstq_cell
// One queue slot: holds an entry, compares it against the broadcast item and
// ripples the "match seen to the left" flag one slot per cycle.
// ----------------------------------------------------------------------------
module dstq_cell
	import dstq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] idx,
	input  bcast_t           bcast,
	input  entry_t           left_entry,
	input  entry_t           right_entry,
	input  logic             chain_in,
	output entry_t           entry,
	output logic             chain_out
);

	entry_t entry_q;
	logic   match_q;
	logic   pre_q;
	logic   in_range;

	assign in_range  = idx < bcast.used;
	assign entry     = entry_q;
	assign chain_out = pre_q | match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			pre_q   <= 1'b0;
		end else begin
			case (bcast.op)
				CP_CMP_INS: begin
					match_q <= in_range && tick_before(bcast.tick, entry_q.tick);
					pre_q   <= 1'b0;
				end
				CP_CMP_REM: begin
					match_q <= in_range && (entry_q.task_id == bcast.task_id);
					pre_q   <= 1'b0;
				end
				CP_SCAN: pre_q <= chain_in;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bcast.op)
			CP_INS: begin
				// slots past the insert point move right by one
				if (pre_q) begin
					entry_q <= left_entry;
				end else if (match_q || idx == bcast.used) begin
					entry_q <= '{task_id: bcast.task_id, tick: bcast.tick};
				end
			end
			CP_REM: begin
				if (pre_q || match_q) begin
					entry_q <= right_entry;
				end
			end
			CP_POP:  entry_q <= right_entry;
			default: ;
		endcase
	end

endmodule

>>> rtl/deadline_sorted_timeout_queue.sv
// ----------------------------------------------------------------------------
// deadline_sorted_timeout_queue
// Queue of task ids kept sorted by wraparound wake tick in a row of cells.
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer when
//  --------+----------------------------------+-----------------------------
//  in      | in_valid, in_ready, in_data      | in_valid && in_ready
//  out     | out_valid, out_ready, out_data   | out_valid && out_ready
//  cfg     | cfg_we, cfg_wdata (forever_tick) | cfg_we
//
// Insert and remove pass through a compare state, a scan state in which the
// match flag ripples down the cell row, and an update state; take due and
// refused operations go straight to the update state. One item is in work at
// a time. A stalled result holds the update state; the next item is taken
// once the result register is loaded.
// Reset empties the queue and sets forever_tick to all ones.
// ----------------------------------------------------------------------------
module deadline_sorted_timeout_queue
	import dstq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_APPLY
	} state_t;

	state_t              state_q;
	in_t                 item_q;
	logic                ok_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [FLAGS_W-1:0]  flags_q;
	logic [SCAN_W-1:0]   scan_q;
	logic [TICK_W-1:0]   forever_q;
	out_t                out_q;
	logic                out_valid_q;

	bcast_t              bcast;
	entry_t              ent   [MAX_TASKS];
	logic                chain [MAX_TASKS+1];
	logic                dec_ok;
	logic                out_free;
	logic [CNT_W-1:0]    cnt_nxt;
	logic [TASK_W-1:0]   taken_nxt;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign chain[0]  = 1'b0;

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		dstq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (CNT_W'(i)),
			.bcast      (bcast),
			.left_entry (ent[(i == 0) ? 0 : i - 1]),
			.right_entry(ent[(i == MAX_TASKS - 1) ? i : i + 1]),
			.chain_in   (chain[i]),
			.entry      (ent[i]),
			.chain_out  (chain[i+1])
		);
	end

	// accept-time decision: is the operation carried out at all
	always_comb begin
		case (in_data.func)
			FN_INSERT:   dec_ok = (in_data.due_tick != forever_q) &&
				!flags_q[in_data.task_id] && (cnt_q < CNT_W'(MAX_TASKS));
			FN_REMOVE:   dec_ok = flags_q[in_data.task_id];
			FN_TAKE_DUE: dec_ok = (cnt_q != '0) &&
				tick_reached(in_data.now_tick, ent[0].tick);
			default:     dec_ok = 1'b0;
		endcase
	end

	always_comb begin
		bcast.op      = CP_HOLD;
		bcast.task_id = item_q.task_id;
		bcast.tick    = item_q.due_tick;
		bcast.used    = cnt_q;
		unique case (state_q)
			ST_CMP:  bcast.op = (item_q.func == FN_INSERT) ? CP_CMP_INS : CP_CMP_REM;
			ST_SCAN: bcast.op = CP_SCAN;
			ST_APPLY: begin
				if (out_free && ok_q) begin
					case (item_q.func)
						FN_INSERT:   bcast.op = CP_INS;
						FN_REMOVE:   bcast.op = CP_REM;
						FN_TAKE_DUE: bcast.op = CP_POP;
						default:     bcast.op = CP_HOLD;
					endcase
				end
			end
			default: bcast.op = CP_HOLD;
		endcase
	end

	// count and popped task after the operation in work
	always_comb begin
		cnt_nxt   = cnt_q;
		taken_nxt = '0;
		if (ok_q) begin
			case (item_q.func)
				FN_INSERT: cnt_nxt = cnt_q + 1'b1;
				FN_REMOVE: cnt_nxt = cnt_q - 1'b1;
				FN_TAKE_DUE: begin
					cnt_nxt   = cnt_q - 1'b1;
					taken_nxt = ent[0].task_id;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forever_q <= '1;
		end else if (cfg_we) begin
			forever_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ok_q        <= 1'b0;
			cnt_q       <= '0;
			flags_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_APPLY) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ok_q <= dec_ok;
						if (dec_ok && (in_data.func == FN_INSERT ||
							in_data.func == FN_REMOVE)) begin
							state_q <= ST_CMP;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_CMP: begin
					scan_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// let the match flag reach the last cell
					if (scan_q == SCAN_W'(MAX_TASKS - 2)) begin
						state_q <= ST_APPLY;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_APPLY: begin
					if (out_free) begin
						out_q.ok          <= ok_q;
						out_q.taken_task  <= taken_nxt;
						out_q.queue_count <= cnt_nxt;
						cnt_q             <= cnt_nxt;
						if (ok_q) begin
							case (item_q.func)
								FN_INSERT:   flags_q[item_q.task_id] <= 1'b1;
								FN_REMOVE:   flags_q[item_q.task_id] <= 1'b0;
								FN_TAKE_DUE: flags_q[ent[0].task_id] <= 1'b0;
								default: ;
							endcase
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/dstq_checker.sv
// ----------------------------------------------------------------------------
// dstq_checker
// Port-level checks for the deadline-sorted timeout queue.
// ----------------------------------------------------------------------------
module dstq_checker
	import dstq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// hold a waiting input transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input changed while waiting");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.queue_count <= CNT_W'(MAX_TASKS))
		else $error("queue count beyond capacity");

	a_taken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.taken_task == '0)
		else $error("taken task set on failed operation");

endmodule

bind deadline_sorted_timeout_queue dstq_checker u_dstq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the deadline-sorted timeout queue. A behavioral copy of the
// queue predicts each result as an operation transfers in; a monitor compares
// every result transfer field by field with the oldest owed result. Directed
// cases, a back-pressure case and three random phases with varying idling
// and forever ticks are run in turn.
// ----------------------------------------------------------------------------
module tb_top;
	import dstq_pkg::*;

	localparam logic [1:0] FN_UNUSED     = 2'd3;
	localparam int         CYCLE_LIMIT   = 1000000;
	localparam int         RX_HOLD_CYCLES = 300;
	localparam int         SETTLE_CYCLES = 2 * (MAX_TASKS + 1) + 8;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_t               in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;
	logic              cfg_we    = 1'b0;
	logic [TICK_W-1:0] cfg_wdata = '0;

	// behavioral copy of the queue
	logic [TASK_W-1:0] mq_task [MAX_TASKS];
	logic [TICK_W-1:0] mq_tick [MAX_TASKS];
	int                mq_used    = 0;
	logic [FLAGS_W-1:0] mq_flags  = '0;
	logic [TICK_W-1:0] mq_forever = '1;

	out_t owed_results [$];
	int   err_cnt     = 0;
	int   cycle_cnt   = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   hold_reqs   = 0;
	int   hold_seen   = 0;
	int   hold_left   = 0;

	deadline_sorted_timeout_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// apply one operation to the behavioral queue and return its result
	task automatic apply_queue_op(input in_t item, output out_t res);
		logic [TICK_W-1:0] d;
		int pos;
		int i;
		logic found;
		res = '0;
		found = 1'b0;
		case (item.func)
			FN_INSERT: begin
				if (item.due_tick != mq_forever && !mq_flags[item.task_id] &&
						mq_used < MAX_TASKS) begin
					pos = mq_used;
					for (i = 0; i < mq_used; i++) begin
						d = item.due_tick - mq_tick[i];
						if (d[TICK_W-1] && !found) begin
							pos = i;
							found = 1'b1;
						end
					end
					for (i = mq_used; i > pos; i--) begin
						mq_task[i] = mq_task[i-1];
						mq_tick[i] = mq_tick[i-1];
					end
					mq_task[pos] = item.task_id;
					mq_tick[pos] = item.due_tick;
					mq_used++;
					mq_flags[item.task_id] = 1'b1;
					res.ok = 1'b1;
				end
			end
			FN_REMOVE: begin
				if (mq_flags[item.task_id]) begin
					pos = -1;
					for (i = 0; i < mq_used; i++)
						if (mq_task[i] == item.task_id && pos < 0)
							pos = i;
					if (pos >= 0) begin
						for (i = pos; i + 1 < mq_used; i++) begin
							mq_task[i] = mq_task[i+1];
							mq_tick[i] = mq_tick[i+1];
						end
						mq_used--;
						mq_flags[item.task_id] = 1'b0;
						res.ok = 1'b1;
					end
				end
			end
			FN_TAKE_DUE: begin
				d = item.now_tick - mq_tick[0];
				if (mq_used > 0 && !d[TICK_W-1]) begin
					res.taken_task = mq_task[0];
					for (i = 0; i + 1 < mq_used; i++) begin
						mq_task[i] = mq_task[i+1];
						mq_tick[i] = mq_tick[i+1];
					end
					mq_used--;
					mq_flags[res.taken_task] = 1'b0;
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		res.queue_count = mq_used[CNT_W-1:0];
	endtask

	// offer one operation, hold it until it transfers, then predict its result
	task automatic send_item(input logic [1:0] func, input logic [TASK_W-1:0] id,
		input logic [TICK_W-1:0] wake, input logic [TICK_W-1:0] now);
		in_t  item;
		out_t res;
		int   gap;
		item.func      = func;
		item.task_id   = id;
		item.due_tick  = wake;
		item.now_tick  = now;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(6, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		apply_queue_op(item, res);
		owed_results.push_back(res);
	endtask

	// drop valid and hold until every owed result has arrived
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_forever(input logic [TICK_W-1:0] value);
		wait_drain();
		repeat (4) @(posedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mq_forever = value;
	endtask

	task automatic test_directed();
		tx_idle_pct = 29;
		rx_idle_pct = 75;
		write_forever(32'hFFFF_FFFF);
		send_item(FN_INSERT,   4'd0,  32'hFFFF_FFFF, 32'h0000_0000);
		send_item(FN_INSERT,   4'd1,  32'd100,       32'hFFFF_FFFF);
		send_item(FN_INSERT,   4'd2,  32'd100,       32'h0000_0000);
		send_item(FN_INSERT,   4'd3,  32'd50,        32'h0000_0000);
		// wraps to just before zero, so it sorts ahead of tick 50
		send_item(FN_INSERT,   4'd15, 32'hFFFF_FFFE, 32'h0000_0000);
		send_item(FN_INSERT,   4'd1,  32'd7,         32'h0000_0000);
		send_item(FN_REMOVE,   4'd7,  32'h0000_0000, 32'h0000_0000);
		send_item(FN_UNUSED,   4'd9,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(FN_TAKE_DUE, 4'd0,  32'h0000_0000, 32'hFFFF_FFFD);
		send_item(FN_TAKE_DUE, 4'd0,  32'h0000_0000, 32'hFFFF_FFFE);
		send_item(FN_TAKE_DUE, 4'd0,  32'h0000_0000, 32'd49);
		send_item(FN_TAKE_DUE, 4'd0,  32'h0000_0000, 32'd50);
		// exactly half the tick space away: counts as before
		send_item(FN_INSERT,   4'd4,  32'h8000_0064, 32'h0000_0000);
		send_item(FN_REMOVE,   4'd2,  32'h0000_0000, 32'h0000_0000);
		send_item(FN_TAKE_DUE, 4'd0,  32'h0000_0000, 32'd100);
		send_item(FN_TAKE_DUE, 4'd0,  32'h0000_0000, 32'h8000_0064);
		send_item(FN_REMOVE,   4'd1,  32'h0000_0000, 32'h0000_0000);
		send_item(FN_TAKE_DUE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(FN_INSERT,   4'd5,  32'h0000_0000, 32'hFFFF_FFFF);
		write_forever(32'h0000_0000);
		send_item(FN_INSERT,   4'd6,  32'h0000_0000, 32'h0000_0000);
		send_item(FN_INSERT,   4'd6,  32'hFFFF_FFFF, 32'h0000_0000);
		send_item(FN_REMOVE,   4'd6,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(FN_REMOVE,   4'd5,  32'h0000_0000, 32'h0000_0000);
		wait_drain();
	endtask

	// fill the queue behind a long receiver hold-off, then empty it in order
	task automatic test_backpressure();
		logic [TICK_W-1:0] base;
		int i;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		base = $urandom | 32'h1;
		hold_reqs++;
		for (i = 0; i < MAX_TASKS; i++)
			send_item(FN_INSERT, i[TASK_W-1:0], base + $urandom_range(20), $urandom);
		send_item(FN_INSERT, 4'd3, base, $urandom);
		for (i = 0; i <= MAX_TASKS; i++)
			send_item(FN_TAKE_DUE, TASK_W'($urandom), $urandom, base + 32'd100);
		wait_drain();
	endtask

	task automatic test_random_phase(input int n_items, input int tx_pct, input int rx_pct,
		input logic [TICK_W-1:0] forever_val, input logic [TICK_W-1:0] start_now);
		logic [TICK_W-1:0] sim_now;
		logic [TICK_W-1:0] wake;
		logic [TICK_W-1:0] now;
		logic [TASK_W-1:0] id;
		int n;
		int r;
		write_forever(forever_val);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sim_now = start_now;
		for (n = 0; n < n_items; n++) begin
			sim_now = sim_now + $urandom_range(40);
			id = TASK_W'($urandom_range(15));
			r = $urandom_range(99);
			if (r < 45) begin
				r = $urandom_range(99);
				if (r < 5)
					wake = mq_forever;
				else if (r < 15)
					wake = $urandom;
				else if (r < 25 && mq_used > 0)
					wake = mq_tick[$urandom_range(mq_used - 1)];
				else
					wake = sim_now + $urandom_range(300);
				send_item(FN_INSERT, id, wake, $urandom);
			end else if (r < 65) begin
				if ($urandom_range(99) < 80 && mq_used > 0)
					id = mq_task[$urandom_range(mq_used - 1)];
				send_item(FN_REMOVE, id, $urandom, $urandom);
			end else if (r < 95) begin
				now = ($urandom_range(99) < 85) ? sim_now : $urandom;
				send_item(FN_TAKE_DUE, id, $urandom, now);
			end else begin
				send_item(FN_UNUSED, id, $urandom, $urandom);
			end
		end
		wait_drain();
	endtask

	// result receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= RX_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_result
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with none owed: ok=%0b task=%0d count=%0d",
					$time, out_data.ok, out_data.taken_task, out_data.queue_count);
				err_cnt++;
			end else begin
				want = owed_results.pop_front();
				if (out_data.ok !== want.ok) begin
					$display("%0t: ok mismatch: expected %0b, actual %0b",
						$time, want.ok, out_data.ok);
					err_cnt++;
				end
				if (out_data.taken_task !== want.taken_task) begin
					$display("%0t: taken_task mismatch: expected %0d, actual %0d",
						$time, want.taken_task, out_data.taken_task);
					err_cnt++;
				end
				if (out_data.queue_count !== want.queue_count) begin
					$display("%0t: queue_count mismatch: expected %0d, actual %0d",
						$time, want.queue_count, out_data.queue_count);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[deadline_sorted_timeout_queue] ERROR");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_phase(570, 29, 75, 32'hFFFF_FFFF, $urandom);
		// start just short of wraparound so ticks cross zero
		test_random_phase(570, 75, 29, $urandom, 32'hFFFF_F000);
		test_random_phase(560, 0, 0, 32'h8000_0000, $urandom);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("[deadline_sorted_timeout_queue] OK");
		else
			$display("[deadline_sorted_timeout_queue] ERROR");
		$finish;
	end

endmodule
